// File: design/srhm_pkg.sv
`default_nettype none

package srhm_pkg;

  // Default sizes of the position counter and of the delay fraction
  localparam int unsigned POS_BITS_DEF  = 24;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Fixed field widths
  localparam int unsigned DLY_W     = 16;
  localparam int unsigned STEP_W    = 24;
  localparam int unsigned FLD_POS_W = 24;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  // Width of the wrapping end-of-move compare
  localparam int unsigned CMP_W     = 32;

  // Register reset values
  localparam logic [CFG_W-1:0] ACCEL_RST = 16'd0;
  localparam logic [CFG_W-1:0] DECEL_RST = 16'd0;
  localparam logic [CFG_W-1:0] SHORT_RST = 16'd10;
  localparam logic [CFG_W-1:0] LONG_RST  = 16'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL = 2'd0,
    CFG_DECEL = 2'd1,
    CFG_SHORT = 2'd2,
    CFG_LONG  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_TICK  = 1'b1
  } req_type_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_DIV   = 3'd1,
    ST_START = 3'd2,
    ST_EVAL  = 3'd3,
    ST_APPLY = 3'd4
  } st_e;

  typedef struct packed {
    logic              req_type;
    logic              move_up;
    logic [STEP_W-1:0] step_count;
    logic [STEP_W-1:0] height_limit;
    logic              limit_pressed;
  } req_t;

  typedef struct packed {
    logic                 step_pulse;
    logic                 step_up;
    logic [DLY_W-1:0]     delay_us;
    logic [FLD_POS_W-1:0] position;
    logic                 homed;
    logic                 move_done;
  } rsp_t;

endpackage

`default_nettype wire

// File: design/srhm_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle
module srhm_div #(
  parameter int unsigned DVD_W = 32,
  parameter int unsigned DVS_W = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] rem_q;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign shifted = {rem_q, quo_q[DVD_W-1]};
  assign fits    = shifted >= {1'b0, divisor_i};
  assign trial   = shifted - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CNT_LOAD;
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNT_ONE;
      busy_q <= cnt_q != CNT_ONE;
    end
  end

  // Shift dividend bits out the top, quotient bits in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], fits};
      rem_q <= fits ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

// File: design/stepper_ramp_homing_move_core.sv
`default_nettype none

// Stepper move controller with trapezoidal delay ramp and limit-switch homing.
// Input channel (in_valid_i / in_stall_o / in_req_i): one beat is either a
// start command (direction, step count, height limit) or a step tick carrying
// the sampled limit-switch level. Every input beat yields exactly one result
// beat on the output channel (out_valid_o / out_stall_i / out_rsp_o).
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the accel and decel
// step counts and the cruise and start delays; write only while no beat is open.
// A tick beat passes through the EVAL and APPLY states and its result is
// registered in APPLY. A start beat waits in DIV for the two bit-serial
// ramp-slope dividers, which produce one quotient bit per cycle, and its
// result is registered in START.
// Items are processed one at a time; a new beat is taken as soon as the
// core is idle, even while the previous result still waits in the output
// register. A stalled receiver holds the result; the core then stalls in
// its last stage until the output register can take the next result.
// Reset clears position, homed flag, move state and slopes, and loads the
// register defaults (cruise delay = start delay = 10).

module stepper_ramp_homing_move_core #(
  parameter int unsigned POS_BITS  = srhm_pkg::POS_BITS_DEF,
  parameter int unsigned FRAC_BITS = srhm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [srhm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [srhm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  srhm_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output srhm_pkg::rsp_t                 out_rsp_o
);

  localparam int unsigned DLY_W  = srhm_pkg::DLY_W;
  localparam int unsigned STEP_W = srhm_pkg::STEP_W;
  localparam int unsigned CMP_W  = srhm_pkg::CMP_W;
  localparam int unsigned FPW    = srhm_pkg::FLD_POS_W;
  localparam int unsigned SPD_W  = DLY_W + FRAC_BITS;

  localparam logic [SPD_W-1:0]    SPD_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [STEP_W-1:0]   IDX_ONE = STEP_W'(1);
  localparam logic [CMP_W-1:0]    CMP_ONE = CMP_W'(1);

  // Configuration registers
  logic [DLY_W-1:0] acc_q, dec_q, dshort_q, dlong_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q    <= srhm_pkg::ACCEL_RST;
      dec_q    <= srhm_pkg::DECEL_RST;
      dshort_q <= srhm_pkg::SHORT_RST;
      dlong_q  <= srhm_pkg::LONG_RST;
    end else if (cfg_we_i) begin
      case (srhm_pkg::cfg_idx_e'(cfg_idx_i))
        srhm_pkg::CFG_ACCEL: acc_q    <= cfg_wdata_i;
        srhm_pkg::CFG_DECEL: dec_q    <= cfg_wdata_i;
        srhm_pkg::CFG_SHORT: dshort_q <= cfg_wdata_i;
        srhm_pkg::CFG_LONG:  dlong_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Move state
  logic [POS_BITS-1:0] pos_q, top_q;
  logic                homed_q, moving_q, dir_q, ramp_q;
  logic [STEP_W-1:0]   idx_q, total_q;
  logic [SPD_W-1:0]    speed_q, arate_q, drate_q;

  // Latched request beat
  srhm_pkg::req_t req_q;

  // Sequencer
  srhm_pkg::st_e state_q, state_d;
  logic          accept, out_free, wr_start, wr_tick, eval_en;
  logic          div_start, div_busy, a_busy, d_busy;
  logic          out_valid_q;

  assign accept    = in_valid_i && !in_stall_o;
  assign out_free  = !out_valid_q || !out_stall_i;
  assign div_start = accept && (in_req_i.req_type == srhm_pkg::REQ_START);
  assign div_busy  = a_busy || d_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srhm_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    wr_start   = 1'b0;
    wr_tick    = 1'b0;
    eval_en    = 1'b0;
    case (state_q)
      srhm_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (in_req_i.req_type == srhm_pkg::REQ_START) ? srhm_pkg::ST_DIV
                                                                : srhm_pkg::ST_EVAL;
        end
      end
      srhm_pkg::ST_DIV: begin
        if (!div_busy) state_d = srhm_pkg::ST_START;
      end
      srhm_pkg::ST_START: begin
        if (out_free) begin
          wr_start = 1'b1;
          state_d  = srhm_pkg::ST_IDLE;
        end
      end
      srhm_pkg::ST_EVAL: begin
        eval_en = 1'b1;
        state_d = srhm_pkg::ST_APPLY;
      end
      srhm_pkg::ST_APPLY: begin
        if (out_free) begin
          wr_tick = 1'b1;
          state_d = srhm_pkg::ST_IDLE;
        end
      end
      default: state_d = srhm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) req_q <= in_req_i;
  end

  // Ramp slopes: (start delay - cruise delay) in fixed point over the step counts
  logic [DLY_W-1:0] dspan;
  logic [SPD_W-1:0] dvd, a_quo, d_quo, arate_new, drate_new;
  logic             ramp_new;

  assign dspan    = dlong_q - dshort_q;
  assign dvd      = {dspan, {FRAC_BITS{1'b0}}};
  assign ramp_new = dlong_q > dshort_q;

  srhm_div #(
    .DVD_W(SPD_W),
    .DVS_W(DLY_W)
  ) u_div_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (acc_q),
    .busy_o     (a_busy),
    .quotient_o (a_quo)
  );

  srhm_div #(
    .DVD_W(SPD_W),
    .DVS_W(DLY_W)
  ) u_div_dec (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd),
    .divisor_i  (dec_q),
    .busy_o     (d_busy),
    .quotient_o (d_quo)
  );

  // A zero step count makes the slope the whole span
  assign arate_new = !ramp_new ? '0 : ((acc_q == '0) ? dvd : a_quo);
  assign drate_new = !ramp_new ? '0 : ((dec_q == '0) ? dvd : d_quo);

  // Tick, EVAL state: register the phase tests
  logic [SPD_W-1:0] short_fx;
  logic [CMP_W-1:0] idx32, total32, acc_end, dec_thr;
  logic             ramping_q, in_acc_q, in_dec_q, last_q, gt_short_q;
  logic [SPD_W-1:0] diff_q;

  assign short_fx = {dshort_q, {FRAC_BITS{1'b0}}};
  assign idx32    = {{(CMP_W - STEP_W){1'b0}}, idx_q};
  assign total32  = {{(CMP_W - STEP_W){1'b0}}, total_q};
  assign acc_end  = {{(CMP_W - DLY_W){1'b0}}, acc_q} + CMP_ONE;
  // Wraps when decel_steps is not less than the move length
  assign dec_thr  = total32 - {{(CMP_W - DLY_W){1'b0}}, dec_q} - CMP_ONE;

  always_ff @(posedge clk_i) begin
    if (eval_en) begin
      ramping_q  <= homed_q && (!dir_q || (pos_q < top_q));
      in_acc_q   <= idx32 < acc_end;
      in_dec_q   <= idx32 > dec_thr;
      last_q     <= (idx32 + CMP_ONE) >= total32;
      gt_short_q <= speed_q > short_fx;
      diff_q     <= speed_q - short_fx;
    end
  end

  // Tick, APPLY state: advance the ramp and the position
  logic [SPD_W:0]      dec_sum;
  logic [SPD_W-1:0]    speed_n, speed_upd;
  logic [DLY_W-1:0]    dly_held, dly;
  logic [POS_BITS-1:0] pos_n;
  logic                homed_n, moving_n, pulse, done;
  logic [STEP_W-1:0]   idx_n;

  assign dec_sum = {1'b0, speed_q} + {1'b0, drate_q};

  always_comb begin
    speed_n = speed_q;
    if (in_acc_q) begin
      // Drop by the slope, clamp at the cruise delay
      speed_n = (gt_short_q && (diff_q > arate_q)) ? (speed_q - arate_q) : short_fx;
    end else if (in_dec_q) begin
      speed_n = dec_sum[SPD_W] ? SPD_MAX : dec_sum[SPD_W-1:0];
    end
  end

  always_comb begin
    pos_n     = pos_q;
    homed_n   = homed_q;
    moving_n  = moving_q;
    idx_n     = idx_q;
    speed_upd = speed_q;
    dly_held  = '0;
    dly       = '0;
    pulse     = 1'b0;
    done      = 1'b0;
    if (moving_q) begin
      if (ramping_q) begin
        if (ramp_q) begin
          speed_upd = speed_n;
          dly_held  = speed_n[SPD_W-1:FRAC_BITS];
        end else begin
          dly_held = dshort_q;
        end
      end else if (req_q.limit_pressed) begin
        // Switch hit while seeking: take the reference and end the move
        homed_n  = 1'b1;
        pos_n    = dir_q ? top_q : '0;
        moving_n = 1'b0;
        done     = 1'b1;
      end
      if (moving_n) begin
        pulse = 1'b1;
        dly   = dly_held;
        if (dir_q) begin
          if (pos_q < POS_MAX) pos_n = pos_q + POS_ONE;
        end else if (pos_q != '0) begin
          pos_n = pos_q - POS_ONE;
        end else begin
          homed_n = 1'b0;
        end
        idx_n = idx_q + IDX_ONE;
        if (last_q) begin
          moving_n = 1'b0;
          done     = 1'b1;
        end
      end
    end
  end

  // Commit state
  logic [POS_BITS+STEP_W-1:0] top_ext;

  assign top_ext = {{POS_BITS{1'b0}}, req_q.height_limit};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      homed_q  <= 1'b0;
      moving_q <= 1'b0;
      dir_q    <= 1'b0;
      idx_q    <= '0;
      total_q  <= '0;
      top_q    <= '0;
      speed_q  <= '0;
      arate_q  <= '0;
      drate_q  <= '0;
      ramp_q   <= 1'b0;
    end else if (wr_start) begin
      dir_q    <= req_q.move_up;
      total_q  <= req_q.step_count;
      top_q    <= top_ext[POS_BITS-1:0];
      idx_q    <= '0;
      moving_q <= req_q.step_count != '0;
      ramp_q   <= ramp_new;
      arate_q  <= arate_new;
      drate_q  <= drate_new;
      speed_q  <= {dlong_q, {FRAC_BITS{1'b0}}};
    end else if (wr_tick) begin
      pos_q    <= pos_n;
      homed_q  <= homed_n;
      moving_q <= moving_n;
      idx_q    <= idx_n;
      speed_q  <= speed_upd;
    end
  end

  // Result beats
  logic [POS_BITS+FPW-1:0] pos_q_ext, pos_n_ext;
  srhm_pkg::rsp_t          rsp_start, rsp_tick, out_rsp_q;

  assign pos_q_ext = {{FPW{1'b0}}, pos_q};
  assign pos_n_ext = {{FPW{1'b0}}, pos_n};

  always_comb begin
    rsp_start            = '0;
    rsp_start.step_up    = req_q.move_up;
    rsp_start.position   = pos_q_ext[FPW-1:0];
    rsp_start.homed      = homed_q;
    rsp_start.move_done  = req_q.step_count == '0;

    rsp_tick             = '0;
    rsp_tick.step_pulse  = pulse;
    rsp_tick.step_up     = dir_q;
    rsp_tick.delay_us    = dly;
    rsp_tick.position    = pos_n_ext[FPW-1:0];
    rsp_tick.homed       = homed_n;
    rsp_tick.move_done   = done;
  end

  // Output register: hold while stalled, load only when free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_start || wr_tick) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_start) begin
      out_rsp_q <= rsp_start;
    end else if (wr_tick) begin
      out_rsp_q <= rsp_tick;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

`default_nettype wire

// File: design/srhm_chk.sv
`default_nettype none

module srhm_chk (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           cfg_we_i,
  input wire logic [srhm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [srhm_pkg::CFG_W-1:0]     cfg_wdata_i,
  input wire logic                           in_valid_i,
  input wire logic                           in_stall_o,
  input wire srhm_pkg::req_t                 in_req_i,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire srhm_pkg::rsp_t                 out_rsp_o
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("result beat changed while stalled");

  // A nonzero delay only comes with an issued step
  a_dly_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.delay_us != '0) |-> out_rsp_o.step_pulse)
    else $error("delay reported without a step");

  // One beat in flight: the core is busy the cycle after it takes a beat
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while one is in flight");

  // A new result only appears after the core was working on a beat
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result beat without a beat in flight");

endmodule

bind stepper_ramp_homing_move_core srhm_chk u_srhm_chk (.*);

`default_nettype wire

// File: sim/stepper_ramp_homing_move_core_tb.sv
`timescale 1ns / 1ps

module stepper_ramp_homing_move_core_tb;
  import srhm_pkg::*;

  // Handshake pressure per phase: which side may idle or stall.
  typedef enum int {
    IDLE_NONE = 0,
    IDLE_SRC  = 1,
    IDLE_SINK = 2,
    IDLE_BOTH = 3
  } idle_mode_e;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 106;
  // A start beat holds the core while the ramp-slope dividers run; wait past that.
  localparam int DRAIN_CYCLES    = 40;
  localparam int SETTLE_CYCLES   = 4;
  localparam int MAX_PRINTS      = 40;

  // Move controller mirror: tracks position, homing and the delay ramp, and
  // queues one expected result beat per accepted request beat.
  class move_scoreboard;
    bit [CFG_W-1:0]     accel_steps, decel_steps, cruise_dly, start_dly;
    bit [FLD_POS_W-1:0] pos, top;
    bit                 homed, moving, dir_up, ramp_on;
    bit [31:0]          idx, total;
    bit [63:0]          speed_fx, accel_rate, decel_rate;
    bit [DLY_W-1:0]     held_delay;
    rsp_t               expected_q[$];
    int                 errors;

    function new();
      accel_steps = ACCEL_RST;
      decel_steps = DECEL_RST;
      cruise_dly  = SHORT_RST;
      start_dly   = LONG_RST;
      errors      = 0;
    endfunction

    function void write_reg(cfg_idx_e sel, bit [CFG_W-1:0] value);
      case (sel)
        CFG_ACCEL: accel_steps = value;
        CFG_DECEL: decel_steps = value;
        CFG_SHORT: cruise_dly  = value;
        CFG_LONG:  start_dly   = value;
        default: ;
      endcase
    endfunction

    // Advance the 16.16 delay along the trapezoid and return its integer part.
    function bit [DLY_W-1:0] next_delay();
      bit [63:0] short_fx, whole;
      short_fx = 64'(cruise_dly) << FRAC_BITS_DEF;
      if (!ramp_on) return cruise_dly;
      if (idx < 32'(accel_steps) + 32'd1) begin
        if (speed_fx > short_fx && speed_fx - short_fx > accel_rate)
          speed_fx = speed_fx - accel_rate;
        else
          speed_fx = short_fx;
      end else if (idx > total - (32'(decel_steps) + 32'd1)) begin
        // the end-of-move compare wraps in 32 bits on purpose
        if (64'hFFFF_FFFF - speed_fx < decel_rate)
          speed_fx = 64'hFFFF_FFFF;
        else
          speed_fx = speed_fx + decel_rate;
      end
      whole = speed_fx >> FRAC_BITS_DEF;
      return (whole > 64'hFFFF) ? 16'hFFFF : whole[15:0];
    endfunction

    function void note(req_t r);
      rsp_t      want;
      bit        ramping;
      bit [63:0] diff;
      want = '0;
      if (r.req_type == REQ_START) begin
        dir_up  = r.move_up;
        total   = 32'(r.step_count);
        top     = r.height_limit;
        idx     = '0;
        moving  = (total != 0);
        want.move_done = !moving;
        ramp_on = (start_dly > cruise_dly);
        if (ramp_on) begin
          diff = (64'(start_dly) - 64'(cruise_dly)) << FRAC_BITS_DEF;
          accel_rate = (accel_steps == 0) ? diff : diff / 64'(accel_steps);
          decel_rate = (decel_steps == 0) ? diff : diff / 64'(decel_steps);
        end else begin
          accel_rate = '0;
          decel_rate = '0;
        end
        speed_fx   = 64'(start_dly) << FRAC_BITS_DEF;
        held_delay = cruise_dly;
      end else if (moving) begin
        ramping = dir_up ? (homed && pos < top) : homed;
        if (ramping) begin
          held_delay = next_delay();
        end else begin
          held_delay = '0;
          if (r.limit_pressed) begin
            homed  = 1'b1;
            pos    = dir_up ? top : '0;
            moving = 1'b0;
            want.move_done = 1'b1;
          end
        end
        if (moving) begin
          want.step_pulse = 1'b1;
          want.delay_us   = held_delay;
          if (dir_up) begin
            if (pos != {FLD_POS_W{1'b1}}) pos = pos + 1'b1;
          end else if (pos != 0) begin
            pos = pos - 1'b1;
          end else begin
            homed = 1'b0;
          end
          idx = idx + 32'd1;
          if (idx >= total) begin
            moving = 1'b0;
            want.move_done = 1'b1;
          end
        end
      end
      want.step_up  = dir_up;
      want.position = pos;
      want.homed    = homed;
      expected_q.push_back(want);
    endfunction

    task report_mismatch(string what, bit [31:0] got, bit [31:0] want);
      if (errors < MAX_PRINTS)
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
      errors++;
    endtask

    task check(rsp_t got);
      rsp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result beat with nothing pending", 32'(got.position), 32'd0);
      end else begin
        want = expected_q.pop_front();
        if (got.step_pulse !== want.step_pulse)
          report_mismatch("step_pulse", 32'(got.step_pulse), 32'(want.step_pulse));
        if (got.step_up !== want.step_up)
          report_mismatch("step_up", 32'(got.step_up), 32'(want.step_up));
        if (got.delay_us !== want.delay_us)
          report_mismatch("delay_us", 32'(got.delay_us), 32'(want.delay_us));
        if (got.position !== want.position)
          report_mismatch("position", 32'(got.position), 32'(want.position));
        if (got.homed !== want.homed)
          report_mismatch("homed", 32'(got.homed), 32'(want.homed));
        if (got.move_done !== want.move_done)
          report_mismatch("move_done", 32'(got.move_done), 32'(want.move_done));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall_o;
  req_t                 in_req;
  logic                 out_valid_o;
  logic                 out_stall = 1'b0;
  rsp_t                 out_rsp_o;

  move_scoreboard sb;
  idle_mode_e     mode = IDLE_NONE;
  int             items_sent = 0;

  stepper_ramp_homing_move_core uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random per phase, change only on the falling edge.
  always @(negedge clk) begin
    out_stall <= (mode == IDLE_SINK) ? ($urandom_range(99) < 51) :
                 (mode == IDLE_BOTH) ? ($urandom_range(99) < 18) : 1'b0;
  end

  // Take every result beat at the rising edge and compare it.
  always @(posedge clk) begin
    if (rst_n && out_valid_o && !out_stall) sb.check(out_rsp_o);
  end

  // Abort when no beat and no register write moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("** stepper_ramp_homing_move_core: FAILED **");
    $finish;
  end

  // Fill every field with noise; callers overwrite what the request uses.
  function automatic req_t noisy_req(req_type_e kind);
    req_t r;
    r.req_type      = kind;
    r.move_up       = 1'($urandom_range(1));
    r.step_count    = STEP_W'($urandom);
    r.height_limit  = STEP_W'($urandom);
    r.limit_pressed = 1'($urandom_range(1));
    return r;
  endfunction

  // Present one request beat and hold it until taken. Leave valid high on
  // return: the next call either replaces the payload or drops valid itself.
  task automatic send_item(req_t r);
    int gap_pct;
    gap_pct = (mode == IDLE_SRC) ? 51 : (mode == IDLE_BOTH) ? 18 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (in_stall_o);
    sb.note(r);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_start(bit up, bit [STEP_W-1:0] count, bit [STEP_W-1:0] height);
    req_t r;
    r = noisy_req(REQ_START);
    r.move_up      = up;
    r.step_count   = count;
    r.height_limit = height;
    send_item(r);
  endtask

  task automatic send_tick(bit pressed);
    req_t r;
    r = noisy_req(REQ_TICK);
    r.limit_pressed = pressed;
    send_item(r);
  endtask

  // Drop valid and wait until every pending result beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e sel, bit [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= sel;
    cfg_wdata <= value;
    sb.write_reg(sel, value);
    @(negedge clk);
  endtask

  task automatic program_regs(bit [CFG_W-1:0] accel, bit [CFG_W-1:0] decel,
                              bit [CFG_W-1:0] dshort, bit [CFG_W-1:0] dlong);
    write_reg(CFG_ACCEL, accel);
    write_reg(CFG_DECEL, decel);
    write_reg(CFG_SHORT, dshort);
    write_reg(CFG_LONG, dlong);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Register settings per phase: hand-picked extremes mixed with random ones.
  task automatic program_phase(int p);
    case (p)
      0: program_regs(16'd4, 16'd3, 16'd100, 16'd1000);
      1: program_regs(16'd0, 16'd0, 16'd10, 16'hFFFF);
      2: program_regs(16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
      3, 6: program_regs(16'($urandom_range(20)), 16'($urandom_range(20)),
                         16'($urandom_range(300)), 16'($urandom_range(3000)));
      4: program_regs(16'd1, 16'd0, 16'hFFFF, 16'd0);
      7: program_regs(16'd0, 16'd12, 16'd0, 16'd0);
      default: program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endcase
  endtask

  // Pick a height a little above the current position, saturating at the top.
  function automatic bit [STEP_W-1:0] height_above(int span);
    bit [STEP_W-1:0] h;
    h = sb.pos + STEP_W'($urandom_range(span));
    if (h < sb.pos) h = '1;
    return h;
  endfunction

  // One random command: mostly well-formed moves, plus homing runs, stray
  // ticks, odd starts and moves cut short by the next start.
  task automatic random_move();
    int              kind, nticks, press_pct;
    bit              up, with_start;
    bit [STEP_W-1:0] count, height;
    kind       = $urandom_range(99);
    up         = 1'($urandom_range(1));
    height     = STEP_W'($urandom);
    with_start = 1'b1;
    if (kind < 45) begin
      count = STEP_W'($urandom_range(1, 40));
      if ($urandom_range(3) != 0) height = height_above(60);
      nticks = ($urandom_range(4) == 0) ? $urandom_range(int'(count))
                                        : int'(count) + $urandom_range(2);
      press_pct = sb.homed ? 10 : 25;
    end else if (kind < 60) begin
      // re-zero upward against a low height limit
      up = 1'b1;
      count = STEP_W'($urandom_range(1, 20));
      if ($urandom_range(3) != 0) height = STEP_W'($urandom_range(40));
      nticks = $urandom_range(1, 3);
      press_pct = 70;
    end else if (kind < 72) begin
      // run down through zero so homed clears, then home on the switch
      up = 1'b0;
      count = (sb.pos < 40) ? sb.pos + STEP_W'($urandom_range(1, 6))
                            : STEP_W'($urandom_range(1, 10));
      nticks = int'(count);
      press_pct = 20;
    end else if (kind < 82) begin
      with_start = 1'b0;
      nticks = $urandom_range(1, 3);
      press_pct = 50;
    end else if (kind < 90) begin
      count = $urandom_range(1) ? STEP_W'(0) : STEP_W'($urandom);
      nticks = $urandom_range(5);
      press_pct = 30;
    end else begin
      up = 1'b1;
      count = STEP_W'($urandom_range(40, 150));
      height = height_above(200);
      nticks = int'(count);
      press_pct = 5;
    end
    if (with_start) send_start(up, count, height);
    repeat (nticks) send_tick($urandom_range(99) < press_pct);
  endtask

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_ACCEL;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_req    = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed opening, no idling: short ramps so the trapezoid shows up.
    program_regs(16'd2, 16'd2, 16'd100, 16'd1000);
    send_tick(1'b0);                        // tick with no move running
    send_start(1'b1, 24'd0, 24'hFFFFFF);    // zero step count ends at once
    send_start(1'b0, 24'hFFFFFF, 24'd0);    // down while not homed
    send_tick(1'b0);                        // step at zero, no reference yet
    send_tick(1'b1);                        // switch homes at zero
    send_start(1'b1, 24'd8, 24'd20);        // full ramp up and down
    for (int i = 0; i < 8; i++) send_tick(i % 3 == 0);  // switch ignored
    send_start(1'b1, 24'd3, 24'd2);         // at or above limit going up
    send_tick(1'b1);                        // re-home at the height limit
    send_start(1'b0, 24'd4, 24'd0);
    repeat (3) send_tick(1'b0);             // last step at zero clears homed
    send_start(1'b1, 24'd3, 24'hFFFFFF);
    send_tick(1'b1);                        // home at the top of the range
    send_start(1'b1, 24'd2, 24'hFFFFFF);
    repeat (2) send_tick(1'b0);             // position saturates
    send_start(1'b0, 24'd1000, 24'd0);
    send_tick(1'b0);
    send_start(1'b0, 24'd2, 24'd0);         // replace a running move
    repeat (2) send_tick(1'b0);

    // Random phases, each with its own register setting and pressure.
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      mode = idle_mode_e'(p % 4);
      program_phase(p);
      while (items_sent < (p + 1) * ITEMS_PER_PHASE) random_move();
    end

    drain();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("** stepper_ramp_homing_move_core: PASSED **");
    else
      $display("** stepper_ramp_homing_move_core: FAILED **");
    $finish;
  end

endmodule

// File: files.f
design/srhm_pkg.sv
design/srhm_div.sv
design/stepper_ramp_homing_move_core.sv
design/srhm_chk.sv
sim/stepper_ramp_homing_move_core_tb.sv
